// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker modules of the receiver core.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must hold on every edge at which result_valid is high.
`define ASSERT_ON_RESULT(label, cond, msg) \
  `ASSERT_CLK(label, result_valid |-> (cond), msg)

`endif

// ===== rtl/core/frwr_pkg.sv =====
// Types, codes and helper functions of the framed register write receiver.
// Used by the interfaces, the core and its checker; depends on nothing.
package frwr_pkg;

  localparam logic [7:0] START_BYTE = 8'hff;
  localparam logic [7:0] END_BYTE   = 8'hfe;
  localparam int         MASK_W     = 16;
  localparam int         ADDR_W     = 7;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_REG,
    PH_DATA
  } phase_t;

  typedef enum logic [0:0] {
    CFG_REG_COUNT,
    CFG_SIZE_CODES
  } cfg_idx_t;

  // Byte offset of register r: the sum of the sizes of all lower registers.
  // The sum is formed as a balanced tree of narrow adds.
  function automatic logic [5:0] reg_offset(logic [31:0] codes, logic [3:0] r);
    logic [1:0] m  [16];
    logic [2:0] l1 [8];
    logic [3:0] l2 [4];
    logic [4:0] l3 [2];
    logic [5:0] sum;
    for (int i = 0; i < 16; i++) begin
      m[i] = (4'(i) < r) ? codes[2*i +: 2] : 2'd0;
    end
    for (int i = 0; i < 8; i++) begin
      l1[i] = {1'b0, m[2*i]} + {1'b0, m[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    sum = {1'b0, l3[0]} + {1'b0, l3[1]};
    return sum + {2'b00, r};
  endfunction

endpackage

// ===== rtl/core/frwr_if.sv =====
// Valid/ready channel interfaces for the receiver's input items and results.
// Depends on frwr_pkg for the mask width.
interface frwr_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic [3:0] read_register;
  logic [1:0] read_offset;

  modport source(output valid, command, rx_byte, read_register, read_offset, input ready);
  modport sink(input valid, command, rx_byte, read_register, read_offset, output ready);
endinterface

interface frwr_result_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_done;
  logic [frwr_pkg::MASK_W-1:0] updated_mask;
  logic                        bad_register;
  logic [7:0]                  read_data;

  modport source(output valid, frame_done, updated_mask, bad_register, read_data, input ready);
  modport sink(input valid, frame_done, updated_mask, bad_register, read_data, output ready);
endinterface

// ===== rtl/core/framed_register_write_receiver_core.sv =====
// Framed register write receiver: parses framed serial bytes into a byte store.
// Depends on frwr_pkg and the channel interfaces in frwr_if.sv.
//
// The block takes one transaction per clock cycle while results are taken, and
// returns one result for each in the cycle after acceptance. The result sits in
// an output register; a new transaction is accepted when no result is waiting or
// in the cycle in which the waiting result is taken, so a stalled result holds
// the input. The parser state is a small register update and the byte store is
// a single memory with one write and one registered read per cycle. The store is
// cleared by reset at once through per-byte valid bits; there is no clearing
// pass. Configuration is written through cfg_en, cfg_index and cfg_data; the user
// must do so only while no transaction is in flight; the block does not
// enforce it.
module framed_register_write_receiver_core #(
  parameter int MAX_REGISTERS = 16,
  parameter int BUFFER_BYTES  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_en,
  input  logic [0:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  frwr_item_if.sink              item,
  frwr_result_if.source          result
);

  localparam int MEM_AW = $clog2(BUFFER_BYTES);

  logic [4:0]                        reg_count;
  logic [31:0]                       size_codes;
  frwr_pkg::phase_t                  phase, phase_next;
  logic [3:0]                        cur_reg, cur_reg_next;
  logic [1:0]                        bytes_left, bytes_left_next;
  logic [frwr_pkg::MASK_W-1:0]       frame_mask, frame_mask_next;

  logic [7:0]                        mem [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0]           mem_vld;
  logic [7:0]                        mem_q;
  logic                              rd_hit;

  logic                              res_vld;
  logic                              res_done;
  logic                              res_bad;
  logic [frwr_pkg::MASK_W-1:0]       res_mask;

  logic                              accept;
  logic [4:0]                        eff_cnt;
  logic [3:0]                        idx;
  logic [1:0]                        idx_code;
  logic [1:0]                        rx_code;
  logic [5:0]                        off;
  logic [1:0]                        pos;
  logic [frwr_pkg::ADDR_W-1:0]       addr;
  logic                              addr_ok;
  logic                              rx_bad;
  logic                              wr_en;
  logic                              rd_en;
  logic                              done_c;
  logic                              bad_c;
  logic [frwr_pkg::MASK_W-1:0]       mask_c;

  assign item.ready = !res_vld || result.ready;
  assign accept     = item.valid && item.ready;

  assign eff_cnt  = (reg_count > 5'(MAX_REGISTERS)) ? 5'(MAX_REGISTERS) : reg_count;
  assign idx      = item.command ? item.read_register : cur_reg;
  assign idx_code = size_codes[{idx, 1'b0} +: 2];
  assign rx_code  = size_codes[{item.rx_byte[3:0], 1'b0} +: 2];
  assign off      = frwr_pkg::reg_offset(size_codes, idx);
  assign pos      = idx_code - bytes_left;
  assign addr     = {1'b0, off} + {5'd0, item.command ? item.read_offset : pos};
  assign addr_ok  = addr < frwr_pkg::ADDR_W'(BUFFER_BYTES);
  assign rx_bad   = item.rx_byte >= {3'b000, eff_cnt};

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    if (!item.command) begin
      unique case (phase)
        frwr_pkg::PH_IDLE: begin
          phase_next = (item.rx_byte == frwr_pkg::START_BYTE) ? frwr_pkg::PH_REG
                                                              : frwr_pkg::PH_IDLE;
        end
        frwr_pkg::PH_REG: begin
          if (item.rx_byte == frwr_pkg::END_BYTE || rx_bad) begin
            phase_next = frwr_pkg::PH_IDLE;
          end else begin
            phase_next = frwr_pkg::PH_DATA;
          end
        end
        frwr_pkg::PH_DATA: begin
          phase_next = (bytes_left == 2'd0) ? frwr_pkg::PH_REG : frwr_pkg::PH_DATA;
        end
        default: phase_next = frwr_pkg::PH_IDLE;
      endcase
    end
  end

  // Parser datapath and result fields.
  always_comb begin
    cur_reg_next    = cur_reg;
    bytes_left_next = bytes_left;
    frame_mask_next = frame_mask;
    done_c          = 1'b0;
    bad_c           = 1'b0;
    mask_c          = frame_mask;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    if (item.command) begin
      rd_en = ({1'b0, item.read_register} < eff_cnt) && (item.read_offset <= idx_code)
              && addr_ok;
    end else begin
      unique case (phase)
        frwr_pkg::PH_IDLE: begin
          if (item.rx_byte == frwr_pkg::START_BYTE) begin
            frame_mask_next = '0;
          end
          mask_c = frame_mask_next;
        end
        frwr_pkg::PH_REG: begin
          if (item.rx_byte == frwr_pkg::END_BYTE) begin
            done_c          = 1'b1;
            frame_mask_next = '0;
          end else if (rx_bad) begin
            bad_c           = 1'b1;
            frame_mask_next = '0;
            mask_c          = '0;
          end else begin
            cur_reg_next    = item.rx_byte[3:0];
            bytes_left_next = rx_code;
          end
        end
        frwr_pkg::PH_DATA: begin
          wr_en = addr_ok;
          if (bytes_left == 2'd0) begin
            frame_mask_next = frame_mask | (frwr_pkg::MASK_W'(1) << cur_reg);
          end else begin
            bytes_left_next = bytes_left - 2'd1;
          end
          mask_c = frame_mask_next;
        end
        default: begin
          mask_c = frame_mask;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count  <= 5'd16;
      size_codes <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        frwr_pkg::CFG_REG_COUNT:  reg_count  <= cfg_data[4:0];
        frwr_pkg::CFG_SIZE_CODES: size_codes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= frwr_pkg::PH_IDLE;
      cur_reg    <= '0;
      bytes_left <= '0;
      frame_mask <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      cur_reg    <= cur_reg_next;
      bytes_left <= bytes_left_next;
      frame_mask <= frame_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[addr[MEM_AW-1:0]] <= item.rx_byte;
    end
    if (accept && rd_en) begin
      mem_q <= mem[addr[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (accept && wr_en) begin
        mem_vld[addr[MEM_AW-1:0]] <= 1'b1;
      end
      if (accept) begin
        rd_hit <= rd_en && mem_vld[addr[MEM_AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (item.ready) begin
      res_vld <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_done <= done_c;
      res_bad  <= bad_c;
      res_mask <= mask_c;
    end
  end

  assign result.valid        = res_vld;
  assign result.frame_done   = res_done;
  assign result.bad_register = res_bad;
  assign result.updated_mask = res_mask;
  assign result.read_data    = rd_hit ? mem_q : 8'd0;

endmodule

// ===== rtl/core/frwr_checker.sv =====
// Port-level checker for the framed register write receiver core.
// Depends on frwr_pkg, assert_macros.svh and the core it is bound to.
`include "assert_macros.svh"

module frwr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic                        frame_done,
  input logic [frwr_pkg::MASK_W-1:0] updated_mask,
  input logic                        bad_register,
  input logic [7:0]                  read_data
);

  `ASSERT_CLK(a_result_held, result_valid && !result_ready |=> result_valid, "result dropped while stalled")
  `ASSERT_CLK(a_clean_after_reset, $past(rst) |-> item_ready && !result_valid, "core not empty after reset")
  `ASSERT_ON_RESULT(a_done_xor_bad, !(frame_done && bad_register), "frame closed and abandoned at once")
  `ASSERT_ON_RESULT(a_bad_mask_zero, !bad_register || updated_mask == '0, "abandoned frame reports a mask")
  `ASSERT_ON_RESULT(a_read_only_data, read_data == 8'd0 || (!frame_done && !bad_register), "read data on a parser result")

endmodule

bind framed_register_write_receiver_core frwr_checker u_frwr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .frame_done   (result.frame_done),
  .updated_mask (result.updated_mask),
  .bad_register (result.bad_register),
  .read_data    (result.read_data)
);

// ===== verif/framed_register_write_receiver_core_checker.sv =====
// Checker for the framed register write receiver: tracks the parser, the frame mask
// and the byte store from the accepted transactions and compares every result.
// Depends on frwr_pkg and the channel interfaces in frwr_if.sv.
module framed_register_write_receiver_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_en,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  frwr_item_if        item,
  frwr_result_if      result,
  output int          fail_count,
  output int          pending
);

  localparam int REG_LIMIT   = 16;
  localparam int STORE_BYTES = 64;

  typedef struct packed {
    logic                        frame_done;
    logic [frwr_pkg::MASK_W-1:0] updated_mask;
    logic                        bad_register;
    logic [7:0]                  read_data;
  } rx_result_t;

  frwr_pkg::phase_t            parse_phase;
  logic [3:0]                  cur_reg;
  logic [1:0]                  bytes_left;
  logic [frwr_pkg::MASK_W-1:0] frame_mask;
  logic [7:0]                  byte_store [STORE_BYTES];
  logic [4:0]                  reg_count;
  logic [31:0]                 size_codes;
  rx_result_t                  expected_q [$];

  function automatic logic [4:0] active_count();
    return (reg_count > 5'(REG_LIMIT)) ? 5'(REG_LIMIT) : reg_count;
  endfunction

  function automatic logic [2:0] size_of(logic [3:0] r);
    return {1'b0, size_codes[2*r +: 2]} + 3'd1;
  endfunction

  function automatic logic [6:0] base_of(logic [3:0] r);
    logic [6:0] sum;
    sum = '0;
    for (int i = 0; i < REG_LIMIT; i++) begin
      if (i < r) sum = sum + 7'(size_of(4'(i)));
    end
    return sum;
  endfunction

  function automatic rx_result_t predict_result(logic cmd, logic [7:0] rx, logic [3:0] rreg,
                                                logic [1:0] roff);
    rx_result_t res;
    logic [6:0] addr;
    logic [1:0] pos;
    res = '0;
    res.updated_mask = frame_mask;
    if (cmd) begin
      if ({1'b0, rreg} < active_count() && {1'b0, roff} < size_of(rreg)) begin
        addr = base_of(rreg) + 7'(roff);
        if (addr < 7'(STORE_BYTES)) res.read_data = byte_store[addr[5:0]];
      end
    end else begin
      case (parse_phase)
        frwr_pkg::PH_REG: begin
          if (rx == frwr_pkg::END_BYTE) begin
            res.frame_done = 1'b1;
            frame_mask = '0;
            parse_phase = frwr_pkg::PH_IDLE;
          end else if (rx >= {3'b000, active_count()}) begin
            res.bad_register = 1'b1;
            res.updated_mask = '0;
            frame_mask = '0;
            parse_phase = frwr_pkg::PH_IDLE;
          end else begin
            cur_reg = rx[3:0];
            bytes_left = 2'(size_of(rx[3:0]) - 3'd1);
            parse_phase = frwr_pkg::PH_DATA;
          end
        end
        frwr_pkg::PH_DATA: begin
          pos = 2'(size_of(cur_reg) - 3'd1 - {1'b0, bytes_left});
          addr = base_of(cur_reg) + 7'(pos);
          if (addr < 7'(STORE_BYTES)) byte_store[addr[5:0]] = rx;
          if (bytes_left == 2'd0) begin
            frame_mask[cur_reg] = 1'b1;
            parse_phase = frwr_pkg::PH_REG;
          end else begin
            bytes_left = bytes_left - 2'd1;
          end
          res.updated_mask = frame_mask;
        end
        default: begin
          if (rx == frwr_pkg::START_BYTE) begin
            parse_phase = frwr_pkg::PH_REG;
            frame_mask = '0;
          end
          res.updated_mask = frame_mask;
        end
      endcase
    end
    return res;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rx_result_t want;
    if (rst) begin
      parse_phase = frwr_pkg::PH_IDLE;
      cur_reg = '0;
      bytes_left = '0;
      frame_mask = '0;
      reg_count = 5'd16;
      size_codes = '0;
      for (int i = 0; i < STORE_BYTES; i++) byte_store[i] = '0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_en) begin
        if (frwr_pkg::cfg_idx_t'(cfg_index) == frwr_pkg::CFG_REG_COUNT) begin
          reg_count = cfg_data[4:0];
        end else begin
          size_codes = cfg_data;
        end
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transaction with none expected, actual %0h/%0h/%0h/%0h",
                   $time, result.frame_done, result.updated_mask, result.bad_register,
                   result.read_data);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("frame_done", want.frame_done, result.frame_done);
          compare_field("updated_mask", want.updated_mask, result.updated_mask);
          compare_field("bad_register", want.bad_register, result.bad_register);
          compare_field("read_data", want.read_data, result.read_data);
        end
      end
      if (item.valid && item.ready) begin
        expected_q.push_back(predict_result(item.command, item.rx_byte, item.read_register,
                                            item.read_offset));
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ===== verif/framed_register_write_receiver_core_tb.sv =====
// Testbench top for the framed register write receiver core: drives directed and
// random framed byte streams, reads and register map changes, and gives the verdict.
// Depends on frwr_pkg, frwr_if.sv, the core and its checker module.
module framed_register_write_receiver_core_tb;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_en;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        idling_on;
  logic [4:0]  map_count;
  logic [31:0] map_codes;
  int          fail_total;
  int          pending;
  int          items_sent;

  frwr_item_if   item_ch();
  frwr_result_if result_ch();

  framed_register_write_receiver_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_en   (cfg_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  framed_register_write_receiver_core_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch),
    .fail_count(fail_total),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !idling_on || ($urandom_range(0, 99) >= 13);
    end
  end

  initial begin
    #3000000;
    $display("framed_register_write_receiver_core_tb: FAIL");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [7:0] b, input logic [3:0] rreg,
                           input logic [1:0] roff);
    if (idling_on) begin
      while ($urandom_range(0, 99) < 13) begin
        item_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_ch.valid         <= 1'b1;
    item_ch.command       <= cmd;
    item_ch.rx_byte       <= b;
    item_ch.read_register <= rreg;
    item_ch.read_offset   <= roff;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_serial(input logic [7:0] b);
    send_item(1'b0, b, 4'($urandom), 2'($urandom));
  endtask

  task automatic send_read(input logic [3:0] rreg, input logic [1:0] roff);
    send_item(1'b1, 8'($urandom), rreg, roff);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_map(input logic [4:0] count, input logic [31:0] codes);
    drain_results();
    cfg_en    <= 1'b1;
    cfg_index <= frwr_pkg::CFG_REG_COUNT;
    cfg_data  <= {27'($urandom), count};
    @(posedge clk);
    cfg_index <= frwr_pkg::CFG_SIZE_CODES;
    cfg_data  <= codes;
    @(posedge clk);
    cfg_en    <= 1'b0;
    map_count = count;
    map_codes = codes;
  endtask

  // Mostly well-formed frames with some interleaved reads; a few carry a bad register number or stop mid-register.
  task automatic send_frame();
    int         live;
    int         nregs;
    int         sz;
    logic [7:0] regnum;
    logic [7:0] data;
    live = (map_count > 5'd16) ? 16 : int'(map_count);
    nregs = $urandom_range(0, 5);
    send_serial(frwr_pkg::START_BYTE);
    for (int i = 0; i < nregs; i++) begin
      if ($urandom_range(0, 9) == 0) send_read(4'($urandom), 2'($urandom));
      if (live == 0 || $urandom_range(0, 24) == 0) begin
        regnum = 8'($urandom_range(live, 255));
        if (regnum == frwr_pkg::END_BYTE) regnum = frwr_pkg::START_BYTE;
        send_serial(regnum);
        return;
      end
      regnum = 8'($urandom_range(0, live - 1));
      send_serial(regnum);
      sz = int'(map_codes[2*regnum[3:0] +: 2]) + 1;
      for (int k = 0; k < sz; k++) begin
        if ($urandom_range(0, 9) == 0) send_read(4'($urandom), 2'($urandom));
        if ($urandom_range(0, 39) == 0) return;
        case ($urandom_range(0, 7))
          0:       data = frwr_pkg::START_BYTE;
          1:       data = frwr_pkg::END_BYTE;
          default: data = 8'($urandom);
        endcase
        send_serial(data);
      end
    end
    send_serial(frwr_pkg::END_BYTE);
  endtask

  initial begin
    int          phase_start;
    logic [4:0]  count;
    logic [31:0] codes;
    rst                   <= 1'b1;
    cfg_en                <= 1'b0;
    cfg_index             <= frwr_pkg::CFG_REG_COUNT;
    cfg_data              <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.command       <= 1'b0;
    item_ch.rx_byte       <= '0;
    item_ch.read_register <= '0;
    item_ch.read_offset   <= '0;
    idling_on = 1'b1;
    items_sent = 0;
    map_count = 5'd16;
    map_codes = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset map: sixteen one-byte registers.
    send_serial(8'h00);
    send_serial(frwr_pkg::END_BYTE);
    send_serial(frwr_pkg::START_BYTE);
    send_read(4'd0, 2'd0);
    send_serial(8'h00);
    send_serial(frwr_pkg::START_BYTE);
    send_serial(8'h0f);
    send_serial(frwr_pkg::END_BYTE);
    send_serial(frwr_pkg::END_BYTE);
    send_read(4'd15, 2'd0);
    send_read(4'd0, 2'd1);
    send_serial(frwr_pkg::START_BYTE);
    send_serial(8'h10);
    send_serial(frwr_pkg::START_BYTE);
    send_serial(frwr_pkg::START_BYTE);

    // An empty map rejects every register number and every read.
    program_map(5'd0, 32'hffff_ffff);
    send_serial(frwr_pkg::START_BYTE);
    send_serial(8'h00);
    send_read(4'd0, 2'd0);

    // A count above sixteen acts as sixteen; four-byte registers.
    program_map(5'd31, 32'hffff_ffff);
    send_serial(frwr_pkg::START_BYTE);
    send_serial(8'h0f);
    send_serial(frwr_pkg::START_BYTE);
    send_serial(frwr_pkg::END_BYTE);
    send_serial(8'h00);
    send_serial(8'h5a);
    send_serial(frwr_pkg::END_BYTE);
    send_read(4'd15, 2'd3);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin count = 5'd16; codes = 32'h0000_0000; end
        1:       begin count = 5'd16; codes = 32'hffff_ffff; end
        2:       begin count = 5'd1;  codes = $urandom; end
        3:       begin count = 5'd31; codes = $urandom; end
        4:       begin count = 5'd0;  codes = $urandom; end
        5:       begin count = 5'($urandom_range(1, 16));  codes = $urandom; end
        6:       begin count = 5'($urandom_range(17, 30)); codes = $urandom; end
        default: begin count = 5'd16; codes = $urandom; end
      endcase
      program_map(count, codes);
      idling_on = (p != 2);
      phase_start = items_sent;
      while (items_sent - phase_start < 244) begin
        case ($urandom_range(0, 39))
          0:                drain_results();
          1, 2, 3, 4, 5:    send_serial(($urandom_range(0, 3) == 0) ? frwr_pkg::END_BYTE
                                                                    : 8'($urandom));
          6, 7, 8, 9:       send_read(4'($urandom), 2'($urandom));
          default:          send_frame();
        endcase
      end
    end

    idling_on = 1'b1;
    drain_results();
    repeat (5) @(posedge clk);
    if (fail_total == 0 && pending == 0) begin
      $display("framed_register_write_receiver_core_tb: PASS");
    end else begin
      $display("framed_register_write_receiver_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/frwr_pkg.sv
rtl/core/frwr_if.sv
rtl/core/framed_register_write_receiver_core.sv
rtl/core/frwr_checker.sv
verif/framed_register_write_receiver_core_checker.sv
verif/framed_register_write_receiver_core_tb.sv
